### hdl/tqsga_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqsga_pkg
// Shared types and constants for the two-queue sticky gate arbiter.
// ----------------------------------------------------------------------------
package tqsga_pkg;

    // defaults for the top level parameters
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ID_WIDTH_DEF    = 16;

    // fixed field widths of the transaction payloads
    localparam int ACTION_W = 2;
    localparam int ID_FIELD_W = 16;
    localparam int TIME_W = 32;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ARRIVE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SERVE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_JUMP   = 2'd2;

    // direction codes
    localparam logic DIR_ENTRY = 1'b0;
    localparam logic DIR_EXIT  = 1'b1;

    // which queue the gate served in the previous slot
    typedef enum logic [2:0] {
        USE_NONE  = 3'b001,
        USE_ENTRY = 3'b010,
        USE_EXIT  = 3'b100
    } last_use_t;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic                  direction;
        logic [ID_FIELD_W-1:0] person_id;
        logic [TIME_W-1:0]     new_time;
    } in_item_t;

    typedef struct packed {
        logic                  crossed;
        logic [ID_FIELD_W-1:0] granted_id;
        logic                  granted_direction;
        logic [TIME_W-1:0]     cross_time;
        logic                  dropped;
    } out_item_t;

    // queue commands from the arbiter
    typedef struct packed {
        logic push;
        logic pop;
    } q_cmd_t;

    // queue status toward the arbiter
    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage

### hdl/tqsga_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqsga_queue
// Circular FIFO of requester ids in a memory, with a registered head word
// that always holds the oldest entry while the queue is not empty.
// ----------------------------------------------------------------------------
module tqsga_queue
    import tqsga_pkg::*;
#(
    parameter int DEPTH  = QUEUE_DEPTH_DEF,
    parameter int DATA_W = ID_FIELD_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  q_cmd_t            cmd,
    input  logic [DATA_W-1:0] push_data,
    output q_status_t         status,
    output logic [DATA_W-1:0] head_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] head_data_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [AW-1:0]     tail_reg;
    logic [AW-1:0]     tail_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    always_comb begin
        head_next = head_reg;
        if (cmd.pop) begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        end
        tail_next = tail_reg;
        if (cmd.push) begin
            tail_next = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
        end
        count_next = count_reg;
        if (cmd.push && !cmd.pop) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.pop && !cmd.push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // read at the next head so the registered head word follows the head pointer;
    // a push landing on that address is forwarded
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[tail_reg] <= push_data;
        end
        if (cmd.push && (tail_reg == head_next)) begin
            head_data_reg <= push_data;
        end else begin
            head_data_reg <= mem[head_next];
        end
    end

    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == CW'(DEPTH));
    assign head_data        = head_data_reg;

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> status.not_empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push && !cmd.pop) |-> !status.full)
        else $error("push into full queue");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == CW'(DEPTH)) |-> (head_reg == tail_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

### hdl/two_queue_sticky_gate_arbiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_queue_sticky_gate_arbiter_top
// Gate arbiter over an entry and an exit queue. Arrivals are queued, or dropped
// when their queue is full, serve transactions grant at most one requester per
// slot with entry kept sticky, and jump transactions reload the slot time.
// ----------------------------------------------------------------------------
//  channel   ports                      direction  payload
//  input     s_valid s_ready s_item     in         in_item_t
//  result    m_valid m_ready m_item     out        out_item_t
//
//  one transaction per cycle sustained while m_ready stays high; each result
//  is registered at the edge its item leaves the input register; the rate is
//  set by the single registered pass: input register, grant logic with the
//  queue heads, result register
//  reset clears pointers, counts, slot time and last-use mark; the queue
//  memories are not cleared and need no clearing pass
//  with m_ready low the result register holds, one more item waits in the
//  input register, then s_ready drops
// ----------------------------------------------------------------------------
module two_queue_sticky_gate_arbiter_top
    import tqsga_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    // ids are kept at no more bits than the result field carries
    localparam int SW = (ID_WIDTH < ID_FIELD_W) ? ID_WIDTH : ID_FIELD_W;

    in_item_t    in_item_reg;
    logic        in_valid_reg;
    out_item_t   out_item_reg;
    out_item_t   out_item_next;
    logic        out_valid_reg;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;
    last_use_t   last_use_reg;
    last_use_t   last_use_next;

    logic        fire;
    logic        is_arrive;
    logic        is_serve;
    logic        is_jump;
    logic        keep_entry;
    logic        pick_entry;
    logic        pick_exit;
    logic        arrive_full;

    q_cmd_t      ent_cmd;
    q_cmd_t      ext_cmd;
    q_status_t   ent_status;
    q_status_t   ext_status;
    logic [SW-1:0] ent_head;
    logic [SW-1:0] ext_head;
    logic [SW-1:0] grant_id;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    assign is_arrive = (in_item_reg.action == ACT_ARRIVE);
    assign is_serve  = (in_item_reg.action == ACT_SERVE);
    assign is_jump   = (in_item_reg.action == ACT_JUMP);

    // entry stays with the gate while it keeps being used, else exit first
    assign keep_entry = ent_status.not_empty && (last_use_reg == USE_ENTRY);
    assign pick_exit  = !keep_entry && ext_status.not_empty;
    assign pick_entry = keep_entry || (!ext_status.not_empty && ent_status.not_empty);

    assign arrive_full = (in_item_reg.direction == DIR_EXIT) ? ext_status.full
                                                             : ent_status.full;

    assign ent_cmd.push = fire && is_arrive && (in_item_reg.direction == DIR_ENTRY)
                          && !ent_status.full;
    assign ext_cmd.push = fire && is_arrive && (in_item_reg.direction == DIR_EXIT)
                          && !ext_status.full;
    assign ent_cmd.pop  = fire && is_serve && pick_entry;
    assign ext_cmd.pop  = fire && is_serve && pick_exit;

    tqsga_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (SW)
    ) u_entry_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (ent_cmd),
        .push_data (in_item_reg.person_id[SW-1:0]),
        .status    (ent_status),
        .head_data (ent_head)
    );

    tqsga_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (SW)
    ) u_exit_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (ext_cmd),
        .push_data (in_item_reg.person_id[SW-1:0]),
        .status    (ext_status),
        .head_data (ext_head)
    );

    assign grant_id = pick_entry ? ent_head : ext_head;

    always_comb begin
        out_item_next = '0;
        time_next     = time_reg;
        last_use_next = last_use_reg;
        if (is_arrive) begin
            out_item_next.dropped = arrive_full;
        end else if (is_serve) begin
            time_next = time_reg + TIME_W'(1);
            if (pick_entry || pick_exit) begin
                out_item_next.crossed           = 1'b1;
                out_item_next.granted_id        = ID_FIELD_W'(grant_id);
                out_item_next.granted_direction = pick_exit ? DIR_EXIT : DIR_ENTRY;
                out_item_next.cross_time        = time_reg;
                last_use_next = pick_entry ? USE_ENTRY : USE_EXIT;
            end else begin
                last_use_next = USE_NONE;
            end
        end else if (is_jump) begin
            time_next     = in_item_reg.new_time;
            last_use_next = USE_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            time_reg      <= '0;
            last_use_reg  <= USE_NONE;
        end else begin
            if (fire) begin
                out_valid_reg <= 1'b1;
                time_reg      <= time_next;
                last_use_reg  <= last_use_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

`ifndef NO_ASSERTIONS
    a_one_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_serve && out_item_next.crossed) |-> $onehot({ent_cmd.pop, ext_cmd.pop}))
        else $error("grant without exactly one queue pop");

    a_serve_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_serve) |=> (time_reg == $past(time_reg) + TIME_W'(1)))
        else $error("slot time did not advance on serve");

    a_grant_or_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.crossed && m_item.dropped))
        else $error("result both granted and dropped");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> ($stable(time_reg) && $stable(last_use_reg)))
        else $error("gate state changed without a transaction");
`endif

endmodule
